/* rtl/core/priority_task_queue_core_assert.svh */
// Assertion macros shared by the queue core.
`ifndef PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH
`define PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PTQ_CHECK(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority task queue check failed");
`define PTQ_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority task queue check failed");
`else
`define PTQ_CHECK(name, ante, cons)
`define PTQ_CHECK_NEXT(name, ante, cons)
`endif
`endif

/* rtl/core/ptq_pkg.sv */
`timescale 1ns / 1ps
package ptq_pkg;

  localparam int PTQ_DEPTH = 16;

  localparam int OPC_W   = 2;
  localparam int PRIO_W  = 3;
  localparam int MIN_W   = 16;
  localparam int TAG_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT5_W  = 5;
  localparam int TOTAL_W = 20;

  localparam logic [CNT5_W-1:0]  MAX5      = 5'd31;
  localparam logic [TOTAL_W-1:0] MAX_TOTAL = 20'hFFFFF;

  localparam logic [OPC_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_MEASURE = 2'd2;
  localparam logic [OPC_W-1:0] OP_SEARCH  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  localparam logic [PRIO_W-1:0] PRIO_L1 = 3'd1;
  localparam logic [PRIO_W-1:0] PRIO_L2 = 3'd2;
  localparam logic [PRIO_W-1:0] PRIO_L3 = 3'd3;
  localparam logic [PRIO_W-1:0] PRIO_L4 = 3'd4;
  localparam logic [PRIO_W-1:0] PRIO_L5 = 3'd5;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [MIN_W-1:0]  mins;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [PRIO_W-1:0] task_priority;
    logic [MIN_W-1:0]  task_minutes;
    logic [TAG_W-1:0]  name_tag;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CNT5_W-1:0]  found_position;
    logic [CNT5_W-1:0]  task_count;
    logic [TOTAL_W-1:0] total_minutes;
    logic [CNT5_W-1:0]  count_level5;
    logic [CNT5_W-1:0]  count_level4;
    logic [CNT5_W-1:0]  count_level3;
    logic [CNT5_W-1:0]  count_level2;
    logic [CNT5_W-1:0]  count_level1;
  } res_t;

  function automatic logic [CNT5_W-1:0] sat_inc5(input logic [CNT5_W-1:0] v);
    return (v == MAX5) ? v : v + 5'd1;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add_total(input logic [TOTAL_W-1:0] acc,
                                                       input logic [MIN_W-1:0] mins);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, acc} + (TOTAL_W + 1)'(mins);
    return sum[TOTAL_W] ? MAX_TOTAL : sum[TOTAL_W-1:0];
  endfunction

endpackage

/* rtl/core/ptq_in_if.sv */
`timescale 1ns / 1ps
interface ptq_in_if import ptq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [PRIO_W-1:0] task_priority;
  logic [MIN_W-1:0]  task_minutes;
  logic [TAG_W-1:0]  name_tag;

  modport source(output valid, output opcode, output task_priority,
                 output task_minutes, output name_tag, input ready);
  modport sink(input valid, input opcode, input task_priority,
               input task_minutes, input name_tag, output ready);
endinterface

/* rtl/core/ptq_out_if.sv */
`timescale 1ns / 1ps
interface ptq_out_if import ptq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [CNT5_W-1:0]  found_position;
  logic [CNT5_W-1:0]  task_count;
  logic [TOTAL_W-1:0] total_minutes;
  logic [CNT5_W-1:0]  count_level5;
  logic [CNT5_W-1:0]  count_level4;
  logic [CNT5_W-1:0]  count_level3;
  logic [CNT5_W-1:0]  count_level2;
  logic [CNT5_W-1:0]  count_level1;

  modport source(output valid, output status, output found_position, output task_count,
                 output total_minutes, output count_level5, output count_level4,
                 output count_level3, output count_level2, output count_level1,
                 input ready);
  modport sink(input valid, input status, input found_position, input task_count,
               input total_minutes, input count_level5, input count_level4,
               input count_level3, input count_level2, input count_level1,
               output ready);
endinterface

/* rtl/core/ptq_mem.sv */
`timescale 1ns / 1ps
module ptq_mem import ptq_pkg::*; #(
  parameter int DEPTH = PTQ_DEPTH,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ptq_engine.sv */
`timescale 1ns / 1ps
`include "priority_task_queue_core_assert.svh"
module ptq_engine import ptq_pkg::*; #(
  parameter int DEPTH = PTQ_DEPTH,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  ptq_in_if.sink           req,
  output logic             res_valid,
  output res_t             res,
  input  logic             res_ready,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output entry_t           mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  entry_t           mem_rdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SAT_W = (CNT_W > CNT5_W) ? CNT_W : CNT5_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ARM   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  iss;
  logic              iss_on;
  logic              pv;
  logic [CNT_W-1:0]  pidx;
  logic [CNT_W-1:0]  pos;
  cmd_t              cmd;
  logic [PRIO_W-1:0] best_prio;
  logic [MIN_W-1:0]  best_mins;

  logic [CNT_W-1:0]  last_idx;
  logic [CNT_W-1:0]  pidx_up;
  logic [CNT_W-1:0]  pidx_dn;
  logic              d_last;
  logic              better;

  function automatic logic [CNT5_W-1:0] clip5(input logic [CNT_W-1:0] v);
    logic [SAT_W-1:0] x;
    x = SAT_W'(v);
    return (x > SAT_W'(MAX5)) ? MAX5 : x[CNT5_W-1:0];
  endfunction

  function automatic res_t status_res(input logic [STAT_W-1:0] s);
    res_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  assign last_idx = occ - ONE;
  assign pidx_up  = pidx + ONE;
  assign pidx_dn  = pidx - ONE;
  assign d_last   = (pidx == last_idx);
  assign better   = (mem_rdata.prio > best_prio) ||
                    ((mem_rdata.prio == best_prio) && (mem_rdata.mins < best_mins));

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign mem_raddr = iss[IDX_W-1:0];
  assign mem_we    = ((state == S_SHIFT) && pv) || (state == S_PUT);

  always_comb begin
    if (state == S_PUT) begin
      mem_waddr = pos[IDX_W-1:0];
      mem_wdata = '{prio: cmd.task_priority, mins: cmd.task_minutes, tag: cmd.name_tag};
    end else if (cmd.opcode == OP_INSERT) begin
      mem_waddr = pidx_up[IDX_W-1:0];
      mem_wdata = mem_rdata;
    end else begin
      mem_waddr = pidx_dn[IDX_W-1:0];
      mem_wdata = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      occ    <= '0;
      iss_on <= 1'b0;
      pv     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd    <= '{opcode: req.opcode, task_priority: req.task_priority,
                        task_minutes: req.task_minutes, name_tag: req.name_tag};
            iss    <= '0;
            iss_on <= 1'b1;
            pv     <= 1'b0;
            unique case (req.opcode)
              OP_INSERT: begin
                priority if (occ == FULL) begin
                  res   <= status_res(ST_FULL);
                  state <= S_DONE;
                end else if (req.task_priority == PRIO_L5 || occ == '0) begin
                  res   <= status_res(ST_OK);
                  pos   <= '0;
                  state <= S_ARM;
                end else if (req.task_priority == PRIO_L1) begin
                  res   <= status_res(ST_OK);
                  pos   <= occ;
                  state <= S_ARM;
                end else begin
                  res   <= status_res(ST_OK);
                  state <= S_SCAN;
                end
              end
              OP_SEARCH: begin
                if (occ == '0) begin
                  res   <= status_res(ST_EMPTY);
                  state <= S_DONE;
                end else begin
                  res   <= status_res(ST_NOT_FOUND);
                  state <= S_SCAN;
                end
              end
              OP_REMOVE, OP_MEASURE: begin
                if (occ == '0) begin
                  res   <= status_res(ST_EMPTY);
                  state <= S_DONE;
                end else begin
                  res   <= status_res(ST_OK);
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end

        S_SCAN: begin
          if (iss_on) begin
            pv   <= 1'b1;
            pidx <= iss;
            if (iss == last_idx) begin
              iss_on <= 1'b0;
            end else begin
              iss <= iss + ONE;
            end
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            unique case (cmd.opcode)
              OP_INSERT: begin
                if (mem_rdata.prio < cmd.task_priority) begin
                  pos   <= pidx;
                  state <= S_ARM;
                end else if (d_last) begin
                  pos   <= occ;
                  state <= S_ARM;
                end
              end
              OP_REMOVE: begin
                if (pidx == '0 || better) begin
                  best_prio <= mem_rdata.prio;
                  best_mins <= mem_rdata.mins;
                  pos       <= pidx;
                end
                if (d_last) begin
                  state <= S_ARM;
                end
              end
              OP_MEASURE: begin
                res.total_minutes <= sat_add_total(res.total_minutes, mem_rdata.mins);
                unique case (mem_rdata.prio)
                  PRIO_L5: res.count_level5 <= sat_inc5(res.count_level5);
                  PRIO_L4: res.count_level4 <= sat_inc5(res.count_level4);
                  PRIO_L3: res.count_level3 <= sat_inc5(res.count_level3);
                  PRIO_L2: res.count_level2 <= sat_inc5(res.count_level2);
                  PRIO_L1: res.count_level1 <= sat_inc5(res.count_level1);
                  default: ;
                endcase
                if (d_last) begin
                  res.task_count <= clip5(occ);
                  state          <= S_DONE;
                end
              end
              OP_SEARCH: begin
                if (mem_rdata.tag == cmd.name_tag) begin
                  res.status         <= ST_OK;
                  res.found_position <= clip5(pidx_up);
                  state              <= S_DONE;
                end else if (d_last) begin
                  state <= S_DONE;
                end
              end
            endcase
          end
        end

        S_ARM: begin
          pv <= 1'b0;
          if (cmd.opcode == OP_INSERT) begin
            iss    <= last_idx;
            iss_on <= (pos != occ);
          end else begin
            iss    <= pos + ONE;
            iss_on <= ((pos + ONE) != occ);
          end
          state <= S_SHIFT;
        end

        S_SHIFT: begin
          if (iss_on) begin
            pv   <= 1'b1;
            pidx <= iss;
            if (cmd.opcode == OP_INSERT) begin
              if (iss == pos) begin
                iss_on <= 1'b0;
              end else begin
                iss <= iss - ONE;
              end
            end else begin
              if (iss == last_idx) begin
                iss_on <= 1'b0;
              end else begin
                iss <= iss + ONE;
              end
            end
          end else begin
            pv <= 1'b0;
          end
          if (!iss_on && !pv) begin
            if (cmd.opcode == OP_INSERT) begin
              state <= S_PUT;
            end else begin
              occ   <= occ - ONE;
              state <= S_DONE;
            end
          end
        end

        S_PUT: begin
          occ   <= occ + ONE;
          state <= S_DONE;
        end

        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PTQ_CHECK(a_occ_bound, 1'b1, occ <= FULL)
  `PTQ_CHECK(a_no_rw_clash, mem_we && iss_on && (state == S_SHIFT), mem_raddr != mem_waddr)
  `PTQ_CHECK(a_put_not_full, state == S_PUT, occ != FULL)
  `PTQ_CHECK_NEXT(a_put_grows, state == S_PUT, occ == $past(occ) + ONE)
  `PTQ_CHECK_NEXT(a_done_holds, (state == S_DONE) && !res_ready,
                  (state == S_DONE) && $stable(res))

endmodule

/* rtl/core/priority_task_queue_core.sv */
`timescale 1ns / 1ps
// Channel  Role    Contents
// req      sink    opcode, task_priority, task_minutes, name_tag
// rsp      source  status, found_position, task_count, total_minutes, count_level5..1
//
// The task list sits in a single memory with one read and one write port, and an
// operation that needs the entries walks them one entry per cycle. Measure and search
// scan the list; remove is a scan followed by a shift, and insert a scan (skipped for
// priorities 5 and 1 and for an empty list) followed by a shift.
// Reset clears the occupancy, the sequencer and the output valid flag; entries need no
// clearing. A new request is taken while the previous response waits in the output
// register; a stalled response holds the sequencer in its final step.
module priority_task_queue_core import ptq_pkg::*; #(
  parameter int DEPTH = PTQ_DEPTH
) (
  input logic       clk,
  input logic       rst,
  ptq_in_if.sink    req,
  ptq_out_if.source rsp
);

  localparam int IDX_W = $clog2(DEPTH);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid;
  res_t out_res;

  ptq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ptq_engine #(
    .DEPTH(DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_res.status;
  assign rsp.found_position = out_res.found_position;
  assign rsp.task_count     = out_res.task_count;
  assign rsp.total_minutes  = out_res.total_minutes;
  assign rsp.count_level5   = out_res.count_level5;
  assign rsp.count_level4   = out_res.count_level4;
  assign rsp.count_level3   = out_res.count_level3;
  assign rsp.count_level2   = out_res.count_level2;
  assign rsp.count_level1   = out_res.count_level1;

endmodule

/* tb/priority_task_queue_core_tb.sv */
`timescale 1ns / 1ps
module priority_task_queue_core_tb;
  import ptq_pkg::*;

  localparam int DEPTH = PTQ_DEPTH;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 40;

  logic clk = 1'b0;
  logic rst;

  ptq_in_if req();
  ptq_out_if rsp();

  priority_task_queue_core u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  entry_t task_list[DEPTH];
  int unsigned list_count;
  res_t pending_results[$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit no_idle;

  always #4 clk = ~clk;

  function automatic logic [CNT5_W-1:0] clip_count(int unsigned v);
    return (v > 31) ? MAX5 : CNT5_W'(v);
  endfunction

  function automatic cmd_t make_cmd(logic [OPC_W-1:0] op, logic [PRIO_W-1:0] prio,
                                    logic [MIN_W-1:0] mins, logic [TAG_W-1:0] tag);
    return '{opcode: op, task_priority: prio, task_minutes: mins, name_tag: tag};
  endfunction

  function automatic cmd_t noise_cmd(logic [OPC_W-1:0] op);
    return make_cmd(op, PRIO_W'($urandom_range(0, 7)), MIN_W'($urandom), $urandom);
  endfunction

  // Applies one command to the shadow task list and returns the response it should produce.
  function automatic res_t apply_command(cmd_t c);
    res_t r;
    int unsigned pos;
    int unsigned best;
    int unsigned level[8];
    longint unsigned sum;
    r = '0;
    case (c.opcode)
      OP_INSERT: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (c.task_priority == PRIO_L5) pos = 0;
          else if (c.task_priority == PRIO_L1) pos = list_count;
          else begin
            pos = 0;
            while (pos < list_count && task_list[pos].prio >= c.task_priority) pos++;
          end
          for (int i = list_count; i > pos; i--) task_list[i] = task_list[i - 1];
          task_list[pos] = '{prio: c.task_priority, mins: c.task_minutes, tag: c.name_tag};
          list_count++;
          r.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < list_count; i++) begin
            if (task_list[i].prio > task_list[best].prio ||
                (task_list[i].prio == task_list[best].prio &&
                 task_list[i].mins < task_list[best].mins)) best = i;
          end
          for (int i = best; i + 1 < list_count; i++) task_list[i] = task_list[i + 1];
          list_count--;
          r.status = ST_OK;
        end
      end
      OP_MEASURE: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          sum = 0;
          foreach (level[k]) level[k] = 0;
          for (int i = 0; i < list_count; i++) begin
            sum += task_list[i].mins;
            level[task_list[i].prio]++;
          end
          r.status = ST_OK;
          r.task_count = clip_count(list_count);
          r.total_minutes = (sum > MAX_TOTAL) ? MAX_TOTAL : TOTAL_W'(sum);
          r.count_level5 = clip_count(level[5]);
          r.count_level4 = clip_count(level[4]);
          r.count_level3 = clip_count(level[3]);
          r.count_level2 = clip_count(level[2]);
          r.count_level1 = clip_count(level[1]);
        end
      end
      OP_SEARCH: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < list_count; i++) begin
            if (r.status == ST_NOT_FOUND && task_list[i].tag == c.name_tag) begin
              r.status = ST_OK;
              r.found_position = clip_count(i + 1);
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_command(cmd_t c);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= c.opcode;
    req.task_priority <= c.task_priority;
    req.task_minutes <= c.task_minutes;
    req.name_tag <= c.name_tag;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(apply_command(c));
  endtask

  task automatic wait_for_drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  task automatic check_response(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      error_count++;
      $display("%0t: response with nothing outstanding, expected none actual status %0d",
               $time, got.status);
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("found_position", 32'(want.found_position), 32'(got.found_position));
    compare_field("task_count", 32'(want.task_count), 32'(got.task_count));
    compare_field("total_minutes", 32'(want.total_minutes), 32'(got.total_minutes));
    compare_field("count_level5", 32'(want.count_level5), 32'(got.count_level5));
    compare_field("count_level4", 32'(want.count_level4), 32'(got.count_level4));
    compare_field("count_level3", 32'(want.count_level3), 32'(got.count_level3));
    compare_field("count_level2", 32'(want.count_level2), 32'(got.count_level2));
    compare_field("count_level1", 32'(want.count_level1), 32'(got.count_level1));
  endtask

  initial begin
    res_t got;
    int unsigned stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      got = '{status: rsp.status, found_position: rsp.found_position,
              task_count: rsp.task_count, total_minutes: rsp.total_minutes,
              count_level5: rsp.count_level5, count_level4: rsp.count_level4,
              count_level3: rsp.count_level3, count_level2: rsp.count_level2,
              count_level1: rsp.count_level1};
      check_response(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_empty_store();
    send_command(noise_cmd(OP_REMOVE));
    send_command(noise_cmd(OP_MEASURE));
    send_command(noise_cmd(OP_SEARCH));
  endtask

  // Out-of-range priorities are stored as given and placed by the general rule.
  task automatic test_insert_placement();
    send_command(make_cmd(OP_INSERT, PRIO_L3, 16'd100, 32'h0000_0011));
    send_command(make_cmd(OP_INSERT, PRIO_L5, 16'h0000, 32'h0000_0000));
    send_command(make_cmd(OP_INSERT, PRIO_L1, 16'hFFFF, 32'hFFFF_FFFF));
    send_command(make_cmd(OP_INSERT, PRIO_L2, 16'd7, 32'h0000_0022));
    send_command(make_cmd(OP_INSERT, PRIO_L4, 16'hFFFF, 32'h0000_0044));
    send_command(make_cmd(OP_INSERT, 3'd0, 16'd5, 32'h0000_0050));
    send_command(make_cmd(OP_INSERT, 3'd6, 16'd6, 32'h0000_0060));
    send_command(make_cmd(OP_INSERT, 3'd7, 16'hFFFF, 32'h0000_0070));
    send_command(noise_cmd(OP_MEASURE));
  endtask

  task automatic test_lookup();
    send_command(make_cmd(OP_SEARCH, PRIO_L1, 16'h0000, 32'h0000_0011));
    send_command(make_cmd(OP_SEARCH, PRIO_L5, 16'hFFFF, 32'hDEAD_BEEF));
    send_command(noise_cmd(OP_REMOVE));
    send_command(make_cmd(OP_SEARCH, PRIO_L3, 16'h1234, 32'h0000_0070));
  endtask

  // Ties on priority and duration fill the store before the rejected insert.
  task automatic test_full_store();
    int unsigned n;
    n = 0;
    while (list_count < DEPTH) begin
      send_command(make_cmd(OP_INSERT, (n % 2) ? PRIO_L4 : PRIO_L2,
                            MIN_W'((n % 3) * 10), 32'h0000_0100 + n));
      n++;
    end
    send_command(make_cmd(OP_INSERT, PRIO_L5, 16'd1, 32'h0000_0BAD));
    send_command(make_cmd(OP_SEARCH, PRIO_L1, 16'd0, 32'hFFFF_FFFF));
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int unsigned insert_share;
    int unsigned pick;
    logic [OPC_W-1:0] op;
    logic [PRIO_W-1:0] prio;
    logic [MIN_W-1:0] mins;
    logic [TAG_W-1:0] tag;
    insert_share = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ((n / 50) % 3)
          0: insert_share = 85;
          1: insert_share = 50;
          default: insert_share = 20;
        endcase
        no_idle = ((n / 50) % 4 == 3);
      end
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      pick = $urandom_range(0, 99);
      if (pick < insert_share) begin
        op = OP_INSERT;
      end else begin
        case ($urandom_range(0, 3))
          0, 1: op = OP_REMOVE;
          2: op = OP_MEASURE;
          default: op = OP_SEARCH;
        endcase
      end
      if ($urandom_range(0, 9) == 0) prio = PRIO_W'($urandom_range(0, 7));
      else prio = PRIO_W'($urandom_range(1, 5));
      case ($urandom_range(0, 3))
        0: mins = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        1: mins = MIN_W'($urandom_range(0, 15));
        default: mins = MIN_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: tag = $urandom_range(0, 7);
        3: tag = 32'hFFFF_FFFF;
        default: tag = $urandom;
      endcase
      if (op == OP_SEARCH && list_count > 0 && $urandom_range(0, 9) < 7)
        tag = task_list[$urandom_range(0, list_count - 1)].tag;
      send_command(make_cmd(op, prio, mins, tag));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.opcode <= OP_MEASURE;
    req.task_priority <= '0;
    req.task_minutes <= '0;
    req.name_tag <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_insert_placement();
    test_lookup();
    test_full_store();
    test_random_traffic();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
